// ===== rtl/skvt_pkg.sv =====
// Shared types, codes and constants for the small key/value table.
`default_nettype none

package skvt_pkg;

    // Default number of key/value slots.
    localparam int DEFAULT_CAPACITY = 16;

    // Field widths of the item payloads.
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Value reported when no stored value is returned (-999).
    localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FC19;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_INS_FULL   = 2'd1,
        STAT_INS_DUP    = 2'd2,
        STAT_DEL_ABSENT = 2'd3
    } status_t;

    // Update commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // append the operation key/value at the first free cell
        logic del;  // delete hit: cells at and above the match take their upper neighbor
    } ctl_t;

endpackage : skvt_pkg

`default_nettype wire

// ===== rtl/skvt_cell.sv =====
// One slot of the key/value chain: stored pair, match logic and neighbor hand-off.
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctl_t               ctl,
    input  wire logic [KEY_W-1:0]   op_key,
    input  wire logic [VALUE_W-1:0] op_value,
    input  wire logic               lower_valid,
    input  wire logic [KEY_W-1:0]   upper_key,
    input  wire logic [VALUE_W-1:0] upper_value,
    input  wire logic               upper_valid,
    input  wire logic               hit_in,
    output logic                    hit_out,
    input  wire logic [VALUE_W-1:0] rdval_in,
    output logic [VALUE_W-1:0]      rdval_out,
    output logic [KEY_W-1:0]        key,
    output logic [VALUE_W-1:0]      value,
    output logic                    valid
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               valid_reg;
    logic               valid_next;
    logic               match;

    // Compare against the operation key; keys are distinct so at most one cell matches.
    assign match     = valid_reg && (key_reg == op_key);
    assign hit_out   = hit_in | match;
    assign rdval_out = rdval_in | (match ? value_reg : '0);

    // Next contents: shift down on a delete at or below this slot, fill on insert.
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.del && hit_out)
        begin
            key_next   = upper_key;
            value_next = upper_value;
            valid_next = upper_valid;
        end
        else if (ctl.ins && !valid_reg && lower_valid)
        begin
            key_next   = op_key;
            value_next = op_value;
            valid_next = 1'b1;
        end
    end

    // Occupancy flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored pair needs no reset; it is only read while the slot is valid.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign valid = valid_reg;

endmodule : skvt_cell

`default_nettype wire

// ===== rtl/small_key_value_table.sv =====
// Top level of the small key/value table: a chain of slot cells and an output register.
//
//  Channel  | Direction | Handshake               | Payload
//  s_axis   | in        | tvalid / tready         | tuser: kind; tdata: key, value_in
//  m_axis   | out       | tvalid / tready         | tdata: found, value_out, status,
//           |           |                         |        entry_count, is_full
//
// One item per clock while the output is not stalled: the key is compared in every cell at once and
// the chain is updated at the accepting edge, where the result is also loaded into the output register.
// The match / shift-down chain through all CAPACITY cells sets the cycle time.
// Reset clears the slot valid bits, the pair count and the output valid; no clearing pass.
// s_axis_tready is low only while a result waits in the output register with m_axis_tready low.
`default_nettype none

module small_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] key, [63:32] value_in
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // [0] found, [32:1] value_out,
                                                      // [34:33] status, [39:35] entry_count,
                                                      // [40] is_full, [47:41] zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [KEY_W-1:0]   op_key;
    logic [VALUE_W-1:0] op_value;
    kind_t              kind;
    logic               is_ins;
    logic               is_del;
    logic               accept;
    logic               full;
    logic               any_hit;
    logic [VALUE_W-1:0] hit_value;
    ctl_t               ctl;
    status_t            status;
    logic [VALUE_W-1:0] value_out;
    logic [CNT_W-1:0]   count_after;

    // Chain wiring between neighboring cells.
    logic               hit_chain   [CAPACITY+1];
    logic [VALUE_W-1:0] rdval_chain [CAPACITY+1];
    logic [KEY_W-1:0]   cell_key    [CAPACITY+1];
    logic [VALUE_W-1:0] cell_value  [CAPACITY+1];
    logic               cell_valid  [CAPACITY+1];
    logic               low_valid   [CAPACITY];

    assign op_key   = s_axis_tdata[KEY_W-1:0];
    assign op_value = s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
    assign kind     = kind_t'(s_axis_tuser);

    // Operation decode; the spare code behaves as a lookup.
    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        unique case (kind)
            KIND_INSERT: is_ins = 1'b1;
            KIND_DELETE: is_del = 1'b1;
            default:     ;
        endcase
    end

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign any_hit = hit_chain[CAPACITY];
    assign hit_value = rdval_chain[CAPACITY];

    assign ctl.ins = accept && is_ins && !any_hit && !full;
    assign ctl.del = accept && is_del && any_hit;

    // Chain ends: nothing below the first cell, an empty slot above the last.
    assign hit_chain[0]         = 1'b0;
    assign rdval_chain[0]       = '0;
    assign cell_key[CAPACITY]   = '0;
    assign cell_value[CAPACITY] = '0;
    assign cell_valid[CAPACITY] = 1'b0;

    // Row of slot cells, each handing its pair to the cell below on a delete.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign low_valid[i] = 1'b1;
        end
        else
        begin : g_rest
            assign low_valid[i] = cell_valid[i-1];
        end

        skvt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .op_key      (op_key),
            .op_value    (op_value),
            .lower_valid (low_valid[i]),
            .upper_key   (cell_key[i+1]),
            .upper_value (cell_value[i+1]),
            .upper_valid (cell_valid[i+1]),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .rdval_in    (rdval_chain[i]),
            .rdval_out   (rdval_chain[i+1]),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i])
        );
    end

    // Result status for the accepted item.
    always_comb
    begin
        status = STAT_DONE;
        if (is_ins && any_hit)
        begin
            status = STAT_INS_DUP;
        end
        else if (is_ins && full)
        begin
            status = STAT_INS_FULL;
        end
        else if (is_del && !any_hit)
        begin
            status = STAT_DEL_ABSENT;
        end
    end

    assign value_out = (!is_ins && !is_del && any_hit) ? hit_value : MISS_VALUE;

    // Pair count follows the cell updates.
    always_comb
    begin
        count_after = count_reg;
        if (ctl.ins)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (ctl.del)
        begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    assign count_next = count_after;

    // Output register: loads on accept, empties when the item is taken.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'b0,
                              (count_after == CNT_W'(CAPACITY)),
                              COUNT_W'(count_after),
                              status,
                              value_out,
                              any_hit};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule : small_key_value_table

`default_nettype wire

// ===== rtl/skvt_checker.sv =====
// Port-level checks for the small key/value table, bound to the top level.
`default_nettype none

module skvt_checker
    import skvt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic               r_found;
    logic [VALUE_W-1:0] r_value;
    logic [1:0]         r_status;
    logic [COUNT_W-1:0] r_count;
    logic               r_full;

    assign r_found  = m_axis_tdata[0];
    assign r_value  = m_axis_tdata[32:1];
    assign r_status = m_axis_tdata[34:33];
    assign r_count  = m_axis_tdata[39:35];
    assign r_full   = m_axis_tdata[40];

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The full flag agrees with the reported count.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_full |-> r_count == COUNT_W'(CAPACITY))
        else $error("full flag with wrong entry count");

    // A duplicate insert was a hit; a failed delete was a miss.
    a_status_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (r_status == STAT_INS_DUP || r_status == STAT_DEL_ABSENT)
        |-> r_found == (r_status == STAT_INS_DUP))
        else $error("status disagrees with found");

    // A dropped insert only happens on a full table.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_status == STAT_INS_FULL |-> r_full)
        else $error("insert dropped while not full");

    // A stored value is only returned on a hit.
    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_value != MISS_VALUE |-> r_found)
        else $error("value returned without a hit");

endmodule : skvt_checker

bind small_key_value_table skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (.*);

`default_nettype wire

// ===== bench/kv_table_checker.sv =====
// Checker for the small key/value table: tracks the table contents and compares every result.
`default_nettype none

module kv_table_checker
    import skvt_pkg::*;
#(
    parameter int SLOTS = DEFAULT_CAPACITY
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] key, [63:32] value_in
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] kind
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,  // [0] found, [32:1] value_out,
                                                      // [34:33] status, [39:35] entry_count,
                                                      // [40] is_full, [47:41] zero
    output int                         failures,
    output int                         outstanding
);

    // One answer of the table, as the block should report it.
    typedef struct packed {
        logic                found;
        logic [VALUE_W-1:0]  value_out;
        status_t             status;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_full;
    } table_answer_t;

    // Shadow copy of the packed table.
    logic [KEY_W-1:0]   key_copy   [SLOTS];
    logic [VALUE_W-1:0] value_copy [SLOTS];
    int                 pairs_held;

    // Answers still owed by the block, oldest first.
    table_answer_t answers_due[$];
    int            mismatch_total;

    // Print one line per mismatch and count it.
    task automatic note_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_total++;
    endtask

    // Apply one operation to the shadow table and work out its answer.
    task automatic apply_table_op(input kind_t op, input logic [KEY_W-1:0] k,
                                  input logic [VALUE_W-1:0] v, output table_answer_t res);
        int slot;
        slot = -1;
        for (int i = 0; i < pairs_held; i++)
        begin
            if (slot < 0 && key_copy[i] == k)
                slot = i;
        end
        res.found     = (slot >= 0);
        res.value_out = MISS_VALUE;
        res.status    = STAT_DONE;
        case (op)
            KIND_INSERT:
            begin
                // A present key wins over the full check.
                if (slot >= 0)
                    res.status = STAT_INS_DUP;
                else if (pairs_held >= SLOTS)
                    res.status = STAT_INS_FULL;
                else
                begin
                    key_copy[pairs_held]   = k;
                    value_copy[pairs_held] = v;
                    pairs_held++;
                end
            end
            KIND_DELETE:
            begin
                if (slot < 0)
                    res.status = STAT_DEL_ABSENT;
                else
                begin
                    // Close the gap: keys and values above the hit move down together.
                    for (int i = slot; i + 1 < pairs_held; i++)
                    begin
                        key_copy[i]   = key_copy[i + 1];
                        value_copy[i] = value_copy[i + 1];
                    end
                    pairs_held--;
                end
            end
            default:
            begin
                // Lookup, and the spare code behaves the same way.
                if (slot >= 0)
                    res.value_out = value_copy[slot];
            end
        endcase
        res.entry_count = pairs_held[COUNT_W-1:0];
        res.is_full     = (pairs_held == SLOTS);
    endtask

    // Watch both channels: check each result, then predict each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            pairs_held     = 0;
            mismatch_total = 0;
            answers_due.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                    note_mismatch("result with nothing expected", m_axis_tdata, '0);
                else
                begin
                    want = answers_due.pop_front();
                    if (m_axis_tdata[0] !== want.found)
                        note_mismatch("found", 48'(m_axis_tdata[0]), 48'(want.found));
                    if (m_axis_tdata[32:1] !== want.value_out)
                        note_mismatch("value_out", 48'(m_axis_tdata[32:1]),
                                      48'(want.value_out));
                    if (m_axis_tdata[34:33] !== want.status)
                        note_mismatch("status", 48'(m_axis_tdata[34:33]), 48'(want.status));
                    if (m_axis_tdata[39:35] !== want.entry_count)
                        note_mismatch("entry_count", 48'(m_axis_tdata[39:35]),
                                      48'(want.entry_count));
                    if (m_axis_tdata[40] !== want.is_full)
                        note_mismatch("is_full", 48'(m_axis_tdata[40]), 48'(want.is_full));
                    if (m_axis_tdata[47:41] !== '0)
                        note_mismatch("padding", 48'(m_axis_tdata[47:41]), '0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_table_op(kind_t'(s_axis_tuser), s_axis_tdata[31:0],
                               s_axis_tdata[63:32], want);
                answers_due.push_back(want);
            end
            failures    <= mismatch_total;
            outstanding <= answers_due.size();
        end
    end

endmodule : kv_table_checker

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, table operations, result back-pressure and the verdict.
`default_nettype none

module testbench
    import skvt_pkg::*;
();

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 800;
    localparam int POOL_SIZE    = 24;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [31:0] key, [63:32] value_in
    logic [1:0]            s_axis_tuser = '0;  // [1:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;      // [0] found, [32:1] value_out, [34:33] status,
                                               // [39:35] entry_count, [40] is_full
    int                    failures;
    int                    outstanding;
    int                    cycle_count = 0;
    bit                    no_gaps = 1'b0;
    logic [KEY_W-1:0]      key_pool [POOL_SIZE];

    small_key_value_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kv_table_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until the table takes it.
    task automatic offer_item(input kind_t op, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Result side: random stalls, a burst phase without stalls, and two long hold-offs.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 200 || taken == 600)
                stall = 80;
            else if (no_gaps)
                stall = 0;
            else
                stall = $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // Operation side: reset, directed cases, random phases, drain and verdict.
    initial
    begin
        int pick;
        int insert_pct;
        int delete_pct;
        kind_t op;
        logic [KEY_W-1:0] k;

        // Key pool small enough that hits, duplicates and a full table are common.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: a lookup miss and a delete of an absent key.
        offer_item(KIND_LOOKUP, 32'h8000_0000, 32'h1234_5678);
        offer_item(KIND_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        // Extreme keys and values.
        offer_item(KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        offer_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        offer_item(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        offer_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Duplicate insert, a hit, and the spare code acting as a lookup.
        offer_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h0000_1234);
        offer_item(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        offer_item(KIND_SPARE, 32'h8000_0000, 32'hFFFF_FFFF);
        // Fill the table to capacity.
        for (int i = 0; i < DEFAULT_CAPACITY - 4; i++)
            offer_item(KIND_INSERT, 32'h100 + i, $urandom);
        // Full table: a new key is dropped, a present key still reports duplicate.
        offer_item(KIND_INSERT, 32'h0BAD_0001, 32'h5555_AAAA);
        offer_item(KIND_INSERT, 32'h8000_0000, 32'hAAAA_5555);
        // Deletes in the middle, at the bottom and at the top, with a lookup after compaction.
        offer_item(KIND_DELETE, 32'h0000_0000, 32'h0);
        offer_item(KIND_DELETE, 32'h8000_0000, 32'h0);
        offer_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        offer_item(KIND_DELETE, 32'h100 + DEFAULT_CAPACITY - 5, 32'h0);

        // Random phases alternate between filling and draining the table.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps    = (n / 100 == 2) || (n / 100 == 5);
            insert_pct = ((n / 100) % 2 == 0) ? 55 : 20;
            delete_pct = ((n / 100) % 2 == 0) ? 15 : 45;
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                op = KIND_INSERT;
            else if (pick < insert_pct + delete_pct)
                op = KIND_DELETE;
            else if ($urandom_range(0, 19) == 0)
                op = KIND_SPARE;
            else
                op = KIND_LOOKUP;
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            offer_item(op, k, $urandom);
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;

        // The count of owed results includes the last item only after the next edge.
        @(posedge clk);
        // Drain the remaining results, then allow for the output register.
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : testbench

`default_nettype wire

// ===== sim.f =====
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/small_key_value_table.sv
rtl/skvt_checker.sv
bench/kv_table_checker.sv
bench/testbench.sv
